>>> rtl/core/mic1dp_pkg.sv
// Mic-1 datapath package: ALU control struct, function and B-bus codes,
// C-bus write mask bit positions and register reset values.
// No dependencies.
package mic1dp_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CTRL_W = 8;
  localparam int unsigned MASK_W = 9;
  localparam int unsigned BSEL_W = 4;

  typedef logic [WORD_W-1:0] word_t;

  typedef enum logic [1:0] {
    FN_AND  = 2'd0,
    FN_OR   = 2'd1,
    FN_NOTB = 2'd2,
    FN_ADD  = 2'd3
  } alu_fn_t;

  typedef struct packed {
    logic    sll8;
    logic    sra1;
    alu_fn_t fn;
    logic    ena;
    logic    enb;
    logic    inva;
    logic    inc;
  } alu_ctrl_t;

  typedef enum logic [BSEL_W-1:0] {
    BSRC_MDR  = 4'd0,
    BSRC_PC   = 4'd1,
    BSRC_MBR  = 4'd2,
    BSRC_MBRU = 4'd3,
    BSRC_SP   = 4'd4,
    BSRC_LV   = 4'd5,
    BSRC_CPP  = 4'd6,
    BSRC_TOS  = 4'd7,
    BSRC_OPC  = 4'd8
  } bsrc_t;

  localparam int unsigned MASK_H   = 8;
  localparam int unsigned MASK_OPC = 7;
  localparam int unsigned MASK_TOS = 6;
  localparam int unsigned MASK_CPP = 5;
  localparam int unsigned MASK_LV  = 4;
  localparam int unsigned MASK_SP  = 3;
  localparam int unsigned MASK_PC  = 2;
  localparam int unsigned MASK_MDR = 1;
  localparam int unsigned MASK_MAR = 0;

  typedef struct packed {
    word_t h;
    word_t opc;
    word_t tos;
    word_t cpp;
    word_t lv;
    word_t sp;
    word_t pc;
    word_t mdr;
    word_t mar;
  } regs_t;

  localparam logic [BYTE_W-1:0] MBR_RESET = 8'h81;
  localparam word_t H_RESET   = 32'd1;
  localparam word_t TOS_RESET = 32'd2;

endpackage

>>> rtl/core/microcoded_stack_cpu_datapath.sv
// Mic-1 style datapath top level: input register, ALU/register step and
// result register. Depends on mic1dp_pkg, mic1dp_alu and mic1dp_regs.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one microinstruction per item:
//   alu_control, write_mask, b_source. Output channel (out_valid/out_ready)
//   returns the C-bus value, N and Z flags and all nine registers after
//   the write. cfg_we/cfg_wdata load the byte register. Items pass the
//   input register, then the result register. Throughput is one item per
//   cycle: the step runs whenever the input register holds an item and
//   the result register is empty or being drained, and the input
//   register refills in the same cycle. The register write and B-bus read of
//   consecutive items chain through the register file each cycle.
//   When the receiver stalls, the result holds, one more item waits in the
//   input register, then in_ready drops.
//   Synchronous reset empties both stages and loads H=1, TOS=2, other
//   registers 0 and the byte register 0x81.
module microcoded_stack_cpu_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mic1dp_pkg::BYTE_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mic1dp_pkg::CTRL_W-1:0] alu_control,
  input  logic [mic1dp_pkg::MASK_W-1:0] write_mask,
  input  logic [mic1dp_pkg::BSEL_W-1:0] b_source,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [31:0]                   alu_output,
  output logic                          negative_flag,
  output logic                          zero_flag,
  output logic [31:0]                   out_holding,
  output logic [31:0]                   out_old_pc,
  output logic [31:0]                   out_top_of_stack,
  output logic [31:0]                   out_constant_pool,
  output logic [31:0]                   out_local_frame,
  output logic [31:0]                   out_stack_pointer,
  output logic [31:0]                   out_program_counter,
  output logic [31:0]                   out_memory_data,
  output logic [31:0]                   out_memory_address
);

  logic                          in_q_valid;
  logic [mic1dp_pkg::CTRL_W-1:0] ctrl_q;
  logic [mic1dp_pkg::MASK_W-1:0] mask_q;
  logic [mic1dp_pkg::BSEL_W-1:0] bsel_q;
  logic                          step;

  mic1dp_pkg::word_t h_value;
  mic1dp_pkg::word_t b_value;
  mic1dp_pkg::word_t c_value;
  mic1dp_pkg::regs_t regs_next;
  mic1dp_pkg::regs_t out_regs;

  assign step     = in_q_valid && (!out_valid || out_ready);
  assign in_ready = !in_q_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_ready) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ctrl_q <= alu_control;
      mask_q <= write_mask;
      bsel_q <= b_source;
    end
  end

  mic1dp_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .mbr_we    (cfg_we),
    .mbr_wdata (cfg_wdata),
    .step      (step),
    .b_source  (bsel_q),
    .write_mask(mask_q),
    .c_value   (c_value),
    .h_value   (h_value),
    .b_value   (b_value),
    .regs_next (regs_next)
  );

  mic1dp_alu u_alu (
    .ctrl   (mic1dp_pkg::alu_ctrl_t'(ctrl_q)),
    .a_value(h_value),
    .b_value(b_value),
    .c_value(c_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      alu_output    <= c_value;
      negative_flag <= c_value[mic1dp_pkg::WORD_W-1];
      zero_flag     <= (c_value == '0);
      out_regs      <= regs_next;
    end
  end

  assign out_holding         = out_regs.h;
  assign out_old_pc          = out_regs.opc;
  assign out_top_of_stack    = out_regs.tos;
  assign out_constant_pool   = out_regs.cpp;
  assign out_local_frame     = out_regs.lv;
  assign out_stack_pointer   = out_regs.sp;
  assign out_program_counter = out_regs.pc;
  assign out_memory_data     = out_regs.mdr;
  assign out_memory_address  = out_regs.mar;

  a_step_fills_out: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("step did not produce a result");

  a_neg_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (negative_flag == alu_output[31]))
    else $error("negative flag mismatch");

  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (zero_flag == (alu_output == 32'd0)))
    else $error("zero flag mismatch");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_q_valid |-> in_ready)
    else $error("input stage empty but not ready");

endmodule

>>> rtl/core/mic1dp_alu.sv
// Mic-1 ALU and shifter, purely combinational.
// Depends on mic1dp_pkg.
module mic1dp_alu (
  input  mic1dp_pkg::alu_ctrl_t ctrl,
  input  mic1dp_pkg::word_t     a_value,
  input  mic1dp_pkg::word_t     b_value,
  output mic1dp_pkg::word_t     c_value
);

  mic1dp_pkg::word_t opa;
  mic1dp_pkg::word_t opb;
  mic1dp_pkg::word_t fn_out;

  always_comb begin
    opa = ctrl.ena ? a_value : '0;
    opb = ctrl.enb ? b_value : '0;
    if (ctrl.inva) begin
      opa = ~opa;
    end
    case (ctrl.fn)
      mic1dp_pkg::FN_AND:  fn_out = opa & opb;
      mic1dp_pkg::FN_OR:   fn_out = opa | opb;
      mic1dp_pkg::FN_NOTB: fn_out = ~opb;
      mic1dp_pkg::FN_ADD:  fn_out = opa + opb + {{(mic1dp_pkg::WORD_W-1){1'b0}}, ctrl.inc};
      default:             fn_out = '0;
    endcase
    if (ctrl.sll8) begin
      c_value = {fn_out[mic1dp_pkg::WORD_W-9:0], 8'h00};
    end else if (ctrl.sra1) begin
      c_value = {fn_out[mic1dp_pkg::WORD_W-1], fn_out[mic1dp_pkg::WORD_W-1:1]};
    end else begin
      c_value = fn_out;
    end
  end

endmodule

>>> rtl/core/mic1dp_regs.sv
// Mic-1 register file: nine 32-bit registers, the byte register, B-bus mux
// and masked C-bus write. Depends on mic1dp_pkg.
module mic1dp_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             mbr_we,
  input  logic [mic1dp_pkg::BYTE_W-1:0]    mbr_wdata,
  input  logic                             step,
  input  logic [mic1dp_pkg::BSEL_W-1:0]    b_source,
  input  logic [mic1dp_pkg::MASK_W-1:0]    write_mask,
  input  mic1dp_pkg::word_t                c_value,
  output mic1dp_pkg::word_t                h_value,
  output mic1dp_pkg::word_t                b_value,
  output mic1dp_pkg::regs_t                regs_next
);

  mic1dp_pkg::regs_t             regs;
  logic [mic1dp_pkg::BYTE_W-1:0] mbr;

  assign h_value = regs.h;

  always_comb begin
    case (b_source)
      mic1dp_pkg::BSRC_MDR:  b_value = regs.mdr;
      mic1dp_pkg::BSRC_PC:   b_value = regs.pc;
      mic1dp_pkg::BSRC_MBR:  b_value = {{(mic1dp_pkg::WORD_W-mic1dp_pkg::BYTE_W){mbr[7]}}, mbr};
      mic1dp_pkg::BSRC_MBRU: b_value = {{(mic1dp_pkg::WORD_W-mic1dp_pkg::BYTE_W){1'b0}}, mbr};
      mic1dp_pkg::BSRC_SP:   b_value = regs.sp;
      mic1dp_pkg::BSRC_LV:   b_value = regs.lv;
      mic1dp_pkg::BSRC_CPP:  b_value = regs.cpp;
      mic1dp_pkg::BSRC_TOS:  b_value = regs.tos;
      mic1dp_pkg::BSRC_OPC:  b_value = regs.opc;
      default:               b_value = '0;
    endcase
  end

  always_comb begin
    regs_next     = regs;
    if (write_mask[mic1dp_pkg::MASK_H])   regs_next.h   = c_value;
    if (write_mask[mic1dp_pkg::MASK_OPC]) regs_next.opc = c_value;
    if (write_mask[mic1dp_pkg::MASK_TOS]) regs_next.tos = c_value;
    if (write_mask[mic1dp_pkg::MASK_CPP]) regs_next.cpp = c_value;
    if (write_mask[mic1dp_pkg::MASK_LV])  regs_next.lv  = c_value;
    if (write_mask[mic1dp_pkg::MASK_SP])  regs_next.sp  = c_value;
    if (write_mask[mic1dp_pkg::MASK_PC])  regs_next.pc  = c_value;
    if (write_mask[mic1dp_pkg::MASK_MDR]) regs_next.mdr = c_value;
    if (write_mask[mic1dp_pkg::MASK_MAR]) regs_next.mar = c_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '{h: mic1dp_pkg::H_RESET, opc: '0, tos: mic1dp_pkg::TOS_RESET,
                cpp: '0, lv: '0, sp: '0, pc: '0, mdr: '0, mar: '0};
      mbr  <= mic1dp_pkg::MBR_RESET;
    end else begin
      if (step) begin
        regs <= regs_next;
      end
      if (mbr_we) begin
        mbr <= mbr_wdata;
      end
    end
  end

endmodule

>>> dv/tb_microcoded_stack_cpu_datapath.sv
// Testbench for microcoded_stack_cpu_datapath: directed and random microinstructions,
// random idling on both channels, and a scoreboard that predicts every result.
// Depends on mic1dp_pkg and the datapath RTL.
module tb_microcoded_stack_cpu_datapath;
  timeunit 1ns;
  timeprecision 1ps;

  class dp_scoreboard;
    typedef struct {
      mic1dp_pkg::word_t c_bus;
      logic              neg;
      logic              zero;
      mic1dp_pkg::regs_t regs;
    } step_t;

    mic1dp_pkg::regs_t             regs;
    logic [mic1dp_pkg::BYTE_W-1:0] byte_reg;
    step_t                         expected_q[$];
    int unsigned                   mismatches;
    int unsigned                   checked;
    int unsigned                   noted;

    function new();
      regs       = '0;
      regs.h     = mic1dp_pkg::H_RESET;
      regs.tos   = mic1dp_pkg::TOS_RESET;
      byte_reg   = mic1dp_pkg::MBR_RESET;
      mismatches = 0;
      checked    = 0;
      noted      = 0;
    endfunction

    function void set_byte(logic [mic1dp_pkg::BYTE_W-1:0] v);
      byte_reg = v;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function mic1dp_pkg::word_t b_bus(logic [mic1dp_pkg::BSEL_W-1:0] sel);
      case (sel)
        mic1dp_pkg::BSRC_MDR:  return regs.mdr;
        mic1dp_pkg::BSRC_PC:   return regs.pc;
        mic1dp_pkg::BSRC_MBR:
          return {{(mic1dp_pkg::WORD_W-mic1dp_pkg::BYTE_W){byte_reg[mic1dp_pkg::BYTE_W-1]}},
                  byte_reg};
        mic1dp_pkg::BSRC_MBRU:
          return {{(mic1dp_pkg::WORD_W-mic1dp_pkg::BYTE_W){1'b0}}, byte_reg};
        mic1dp_pkg::BSRC_SP:   return regs.sp;
        mic1dp_pkg::BSRC_LV:   return regs.lv;
        mic1dp_pkg::BSRC_CPP:  return regs.cpp;
        mic1dp_pkg::BSRC_TOS:  return regs.tos;
        mic1dp_pkg::BSRC_OPC:  return regs.opc;
        default:               return '0;
      endcase
    endfunction

    function mic1dp_pkg::word_t shifter_out(mic1dp_pkg::alu_ctrl_t ctl, mic1dp_pkg::word_t b);
      mic1dp_pkg::word_t opa;
      mic1dp_pkg::word_t opb;
      mic1dp_pkg::word_t s;
      opa = ctl.ena ? regs.h : '0;
      opb = ctl.enb ? b : '0;
      if (ctl.inva) opa = ~opa;
      case (ctl.fn)
        mic1dp_pkg::FN_AND:  s = opa & opb;
        mic1dp_pkg::FN_OR:   s = opa | opb;
        mic1dp_pkg::FN_NOTB: s = ~opb;
        default:             s = opa + opb + {31'd0, ctl.inc};
      endcase
      if (ctl.sll8) s = s << 8;
      else if (ctl.sra1) s = {s[mic1dp_pkg::WORD_W-1], s[mic1dp_pkg::WORD_W-1:1]};
      return s;
    endfunction

    function void note_item(logic [mic1dp_pkg::CTRL_W-1:0] ctrl,
                            logic [mic1dp_pkg::MASK_W-1:0] mask,
                            logic [mic1dp_pkg::BSEL_W-1:0] bsel);
      step_t             e;
      mic1dp_pkg::word_t c;
      c = shifter_out(mic1dp_pkg::alu_ctrl_t'(ctrl), b_bus(bsel));
      if (mask[mic1dp_pkg::MASK_H])   regs.h   = c;
      if (mask[mic1dp_pkg::MASK_OPC]) regs.opc = c;
      if (mask[mic1dp_pkg::MASK_TOS]) regs.tos = c;
      if (mask[mic1dp_pkg::MASK_CPP]) regs.cpp = c;
      if (mask[mic1dp_pkg::MASK_LV])  regs.lv  = c;
      if (mask[mic1dp_pkg::MASK_SP])  regs.sp  = c;
      if (mask[mic1dp_pkg::MASK_PC])  regs.pc  = c;
      if (mask[mic1dp_pkg::MASK_MDR]) regs.mdr = c;
      if (mask[mic1dp_pkg::MASK_MAR]) regs.mar = c;
      e.c_bus = c;
      e.neg   = c[mic1dp_pkg::WORD_W-1];
      e.zero  = (c == '0);
      e.regs  = regs;
      expected_q = {expected_q, e};
      noted++;
    endfunction

    task report_mismatch(string field, mic1dp_pkg::word_t got, mic1dp_pkg::word_t want);
      $display("[%0t] result %0d %s: got %h, expected %h", $time, checked, field, got, want);
      mismatches++;
    endtask

    task check_result(mic1dp_pkg::word_t c, logic n, logic z, mic1dp_pkg::regs_t got);
      step_t e;
      string reg_name[9] = '{"MAR", "MDR", "PC", "SP", "LV", "CPP", "TOS", "OPC", "H"};
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", c, '0);
        return;
      end
      e = expected_q.pop_front();
      if (c !== e.c_bus) report_mismatch("alu_output", c, e.c_bus);
      if (n !== e.neg) report_mismatch("negative_flag", {31'd0, n}, {31'd0, e.neg});
      if (z !== e.zero) report_mismatch("zero_flag", {31'd0, z}, {31'd0, e.zero});
      for (int i = 0; i < 9; i++) begin
        if (got[i*mic1dp_pkg::WORD_W +: mic1dp_pkg::WORD_W] !==
            e.regs[i*mic1dp_pkg::WORD_W +: mic1dp_pkg::WORD_W])
          report_mismatch(reg_name[i], got[i*mic1dp_pkg::WORD_W +: mic1dp_pkg::WORD_W],
                          e.regs[i*mic1dp_pkg::WORD_W +: mic1dp_pkg::WORD_W]);
      end
      checked++;
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          cfg_we = 1'b0;
  logic [mic1dp_pkg::BYTE_W-1:0] cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [mic1dp_pkg::CTRL_W-1:0] alu_control = '0;
  logic [mic1dp_pkg::MASK_W-1:0] write_mask = '0;
  logic [mic1dp_pkg::BSEL_W-1:0] b_source = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [31:0]                   alu_output;
  logic                          negative_flag;
  logic                          zero_flag;
  logic [31:0]                   out_holding;
  logic [31:0]                   out_old_pc;
  logic [31:0]                   out_top_of_stack;
  logic [31:0]                   out_constant_pool;
  logic [31:0]                   out_local_frame;
  logic [31:0]                   out_stack_pointer;
  logic [31:0]                   out_program_counter;
  logic [31:0]                   out_memory_data;
  logic [31:0]                   out_memory_address;

  dp_scoreboard sb;
  bit           quiet = 1'b0;
  int unsigned  byte_settings = 1;

  microcoded_stack_cpu_datapath u_dut (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .alu_control         (alu_control),
    .write_mask          (write_mask),
    .b_source            (b_source),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .alu_output          (alu_output),
    .negative_flag       (negative_flag),
    .zero_flag           (zero_flag),
    .out_holding         (out_holding),
    .out_old_pc          (out_old_pc),
    .out_top_of_stack    (out_top_of_stack),
    .out_constant_pool   (out_constant_pool),
    .out_local_frame     (out_local_frame),
    .out_stack_pointer   (out_stack_pointer),
    .out_program_counter (out_program_counter),
    .out_memory_data     (out_memory_data),
    .out_memory_address  (out_memory_address)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stall bursts, none in the quiet tail
  always begin
    @(posedge clk);
    if (!rst && !quiet && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    out_ready <= 1'b1;
    repeat ($urandom_range(1, 24)) @(posedge clk);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(alu_output, negative_flag, zero_flag,
                      {out_holding, out_old_pc, out_top_of_stack, out_constant_pool,
                       out_local_frame, out_stack_pointer, out_program_counter,
                       out_memory_data, out_memory_address});
  end

  task automatic send_item(logic [mic1dp_pkg::CTRL_W-1:0] c,
                           logic [mic1dp_pkg::MASK_W-1:0] m,
                           logic [mic1dp_pkg::BSEL_W-1:0] b);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    alu_control <= c;
    write_mask  <= m;
    b_source    <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_item(c, m, b);
  endtask

  task automatic send_random_item();
    logic [mic1dp_pkg::CTRL_W-1:0] c;
    logic [mic1dp_pkg::MASK_W-1:0] m;
    logic [mic1dp_pkg::BSEL_W-1:0] b;
    c = mic1dp_pkg::CTRL_W'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0:       m = '0;
      1:       m = '1;
      2, 3, 4: m = 9'd1 << $urandom_range(0, 8);
      default: m = mic1dp_pkg::MASK_W'($urandom_range(0, 511));
    endcase
    b = ($urandom_range(0, 5) == 0) ? mic1dp_pkg::BSEL_W'($urandom_range(9, 15))
                                    : mic1dp_pkg::BSEL_W'($urandom_range(0, 8));
    send_item(c, m, b);
  endtask

  // sender holds off until all results are back, then lets the pipeline settle
  task automatic drain_results();
    int unsigned waited;
    in_valid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_byte(logic [mic1dp_pkg::BYTE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_byte(v);
    byte_settings++;
  endtask

  task automatic run_directed();
    send_item(8'h3D, 9'h100, mic1dp_pkg::BSRC_TOS);   // H = H + TOS + 1
    send_item(8'h39, 9'h080, mic1dp_pkg::BSRC_MDR);   // OPC = H + 1
    send_item(8'h36, 9'h040, mic1dp_pkg::BSRC_OPC);   // TOS = OPC - 1 via inverted A
    send_item(8'hB4, 9'h020, mic1dp_pkg::BSRC_MBRU);  // shift left 8
    send_item(8'h74, 9'h010, mic1dp_pkg::BSRC_MBR);   // arithmetic shift right 1
    send_item(8'hF4, 9'h008, mic1dp_pkg::BSRC_LV);    // both shifts: left wins
    send_item(8'h20, 9'h004, mic1dp_pkg::BSRC_SP);    // NOT B with B disabled
    send_item(8'h3D, 9'h002, mic1dp_pkg::BSRC_PC);    // add wraps
    send_item(8'h1A, 9'h001, mic1dp_pkg::BSRC_CPP);   // OR with inverted A
    send_item(8'h0F, 9'h000, mic1dp_pkg::BSRC_MDR);   // AND with inc, empty mask
    send_item(8'h1D, 9'h0AA, mic1dp_pkg::BSRC_SP);    // OR with inc
    send_item(8'h2C, 9'h155, mic1dp_pkg::BSRC_TOS);   // NOT B ignores A
    for (int s = 9; s <= 15; s++)
      send_item(8'h3C, 9'h1 << (s - 9), s[mic1dp_pkg::BSEL_W-1:0]);
    send_item(8'h00, 9'h000, mic1dp_pkg::BSRC_MDR);   // zero result
    send_item(8'hFF, 9'h1FF, 4'hF);
    send_item(8'h3C, 9'h1FF, mic1dp_pkg::BSRC_MBR);
  endtask

  initial begin
    logic [mic1dp_pkg::BYTE_W-1:0] settings[$];
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    settings = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    repeat (4) settings = {settings, mic1dp_pkg::BYTE_W'($urandom_range(0, 255))};
    foreach (settings[p]) begin
      drain_results();
      write_byte(settings[p]);
      if (p == settings.size() - 1) quiet = 1'b1;
      repeat (150) send_random_item();
    end
    drain_results();
    if (sb.pending() != 0) begin
      $display("%0d expected results never arrived", sb.pending());
      sb.mismatches += sb.pending();
    end
    $display("Ran %0d microinstructions under %0d byte register values; %0d results checked.",
             sb.noted, byte_settings, sb.checked);
    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end

endmodule
